FILE: src/hpf_pkg.sv
package hpf_pkg;

  // datapath widths
  localparam int ST_W   = 40;  // filter state, saturated
  localparam int ACC_W  = 44;  // accumulator, headroom over state
  localparam int OP_W   = 26;  // multiplier operand (signed)
  localparam int COEF_W = 25;  // unsigned coefficient, 24 fraction bits
  localparam int PROD_W = 52;  // OP_W + COEF_W + 1
  localparam int TMP_W  = 26;  // rounded low partial product
  localparam int OUT_W  = 24;
  localparam int IN_W   = 16;

  // configuration register indexes
  localparam logic [1:0] REG_INPUT_MODE = 2'd0;
  localparam logic [1:0] REG_BYPASS     = 2'd1;

  typedef logic signed [ST_W-1:0]   state_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic        [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // pole coefficients and output gain, value * 2^24 rounded
  localparam coef_t K_A1   = 25'd31190120;  // 1.859076
  localparam coef_t K_A2   = 25'd14509354;  // 0.8648249
  localparam coef_t K_B1   = 25'd32475909;  // 1.935715
  localparam coef_t K_B2   = 25'd15799111;  // 0.9417004
  localparam coef_t K_GAIN = 25'd15140229;  // 0.902428

  // clamp accumulator value to the 40-bit state range
  function automatic state_t sat_state(input acc_t v);
    logic fits;
    fits = (v[ACC_W-1:ST_W-1] == '0) || (v[ACC_W-1:ST_W-1] == '1);
    if (fits) begin
      sat_state = v[ST_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat_state = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      sat_state = {1'b0, {(ST_W-1){1'b1}}};
    end
  endfunction

  // clamp accumulator value to the 24-bit output range
  function automatic logic signed [OUT_W-1:0] sat_out(input acc_t v);
    logic fits;
    fits = (v[ACC_W-1:OUT_W-1] == '0) || (v[ACC_W-1:OUT_W-1] == '1);
    if (fits) begin
      sat_out = v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: src/highpass_100hz_two_biquad.sv
// 100 Hz high-pass, two cascaded biquads and output gain, one shared multiplier.
// Each item takes the ten partial products of the single 26x26 multiplier plus
// the add and saturate steps per section; in_stall is high outside idle, so a
// new item is accepted only once the previous one has left the sequencer.
// A full output register holds the block in its last step until it is taken.
// Sync reset (rst_n low) clears filter state, sequencer, config and valid only.
module highpass_100hz_two_biquad import hpf_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_filtered,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [0:0]              cfg_data
);

  localparam int OUT_SHIFT = FRACTION_BITS - 8;
  localparam acc_t OUT_RND = (OUT_SHIFT > 0) ? (acc_t'(1) <<< (OUT_SHIFT - 1)) : '0;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;   // lo(last) * a
  localparam logic [3:0] ST_M1   = 4'd2;   // hi(last) * a
  localparam logic [3:0] ST_M2   = 4'd3;   // lo(older) * b
  localparam logic [3:0] ST_M3   = 4'd4;   // hi(older) * b
  localparam logic [3:0] ST_M4   = 4'd5;   // drain last product
  localparam logic [3:0] ST_E    = 4'd6;   // pole output
  localparam logic [3:0] ST_Y    = 4'd7;   // double zero, state shift
  localparam logic [3:0] ST_G0   = 4'd8;   // lo(y) * gain
  localparam logic [3:0] ST_G1   = 4'd9;   // hi(y) * gain
  localparam logic [3:0] ST_G2   = 4'd10;  // drain gain product
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]              st_r, st_nxt;
  logic                    sec_r, sec_nxt;
  acc_t                    acc_r, acc_nxt;
  logic [TMP_W-1:0]        tmp_r, tmp_nxt;
  acc_t                    x_r, x_nxt;
  state_t                  e_r, e_nxt;
  state_t                  l1_r, l1_nxt, o1_r, o1_nxt;
  state_t                  l2_r, l2_nxt, o2_r, o2_nxt;
  logic signed [IN_W-1:0]  sample_r, sample_nxt;
  logic                    mode_r, byp_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_filtered_r, out_filtered_nxt;

  state_t                  last_sel, older_sel, mul_src;
  coef_t                   ca_sel, cb_sel, coef_sel;
  op_t                     op_sel;
  prod_t                   prod_r;
  logic [TMP_W+23:0]       lo_sum;
  acc_t                    term, in_ext, y_sum, out_rnd;
  logic signed [OUT_W-1:0] byp_val;
  logic                    accept, out_free;

  assign in_stall     = (st_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign accept       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;

  // section operand and coefficient select
  assign last_sel  = sec_r ? l2_r : l1_r;
  assign older_sel = sec_r ? o2_r : o1_r;
  assign ca_sel    = sec_r ? K_B1 : K_A1;
  assign cb_sel    = sec_r ? K_B2 : K_A2;

  always_comb begin
    case (st_r)
      ST_M0, ST_M1: begin
        mul_src  = last_sel;
        coef_sel = ca_sel;
      end
      ST_M2, ST_M3: begin
        mul_src  = older_sel;
        coef_sel = cb_sel;
      end
      default: begin
        mul_src  = x_r[ST_W-1:0];
        coef_sel = K_GAIN;
      end
    endcase
    if (st_r == ST_M0 || st_r == ST_M2 || st_r == ST_G0) begin
      op_sel = {2'b00, mul_src[23:0]};
    end else begin
      op_sel = {{(OP_W-16){mul_src[ST_W-1]}}, mul_src[ST_W-1:24]};
    end
  end

  hpf_mul u_mul (
    .clk    (clk),
    .op_a   (op_sel),
    .coef   (coef_sel),
    .prod_r (prod_r)
  );

  // rounding of the low partial product, then full term
  assign lo_sum  = prod_r[TMP_W+23:0] + (TMP_W+24)'(24'h800000);
  assign term    = $signed(prod_r[ACC_W-1:0]) + $signed({{(ACC_W-TMP_W){1'b0}}, tmp_r});
  assign in_ext  = acc_t'(in_sample) <<< (mode_r ? (FRACTION_BITS - 3) : FRACTION_BITS);
  assign y_sum   = acc_t'(e_r) - (acc_t'(last_sel) <<< 1) + acc_t'(older_sel);
  assign out_rnd = (acc_r + OUT_RND) >>> OUT_SHIFT;
  assign byp_val = (OUT_W'(sample_r)) <<< (mode_r ? 5 : 8);

  // sequencer and datapath next state
  always_comb begin
    st_nxt           = st_r;
    sec_nxt          = sec_r;
    acc_nxt          = acc_r;
    tmp_nxt          = tmp_r;
    x_nxt            = x_r;
    e_nxt            = e_r;
    l1_nxt           = l1_r;
    o1_nxt           = o1_r;
    l2_nxt           = l2_r;
    o2_nxt           = o2_r;
    sample_nxt       = sample_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_filtered_nxt = out_filtered_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt     = ST_M0;
          sec_nxt    = 1'b0;
          acc_nxt    = '0;
          x_nxt      = in_ext;
          sample_nxt = in_sample;
        end
      end
      ST_M0: st_nxt = ST_M1;
      ST_M1: begin
        tmp_nxt = lo_sum[TMP_W+23:24];
        st_nxt  = ST_M2;
      end
      ST_M2: begin
        acc_nxt = acc_r + term;
        st_nxt  = ST_M3;
      end
      ST_M3: begin
        tmp_nxt = lo_sum[TMP_W+23:24];
        st_nxt  = ST_M4;
      end
      ST_M4: begin
        acc_nxt = acc_r - term;
        st_nxt  = ST_E;
      end
      ST_E: begin
        e_nxt  = sat_state(acc_r + x_r);
        st_nxt = ST_Y;
      end
      ST_Y: begin
        x_nxt   = acc_t'(sat_state(y_sum));
        acc_nxt = '0;
        sec_nxt = ~sec_r;
        if (sec_r) begin
          o2_nxt = l2_r;
          l2_nxt = e_r;
          st_nxt = ST_G0;
        end else begin
          o1_nxt = l1_r;
          l1_nxt = e_r;
          st_nxt = ST_M0;
        end
      end
      ST_G0: st_nxt = ST_G1;
      ST_G1: begin
        tmp_nxt = lo_sum[TMP_W+23:24];
        st_nxt  = ST_G2;
      end
      ST_G2: begin
        acc_nxt = acc_r + term;
        st_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = byp_r ? byp_val : sat_out(out_rnd);
          st_nxt           = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sec_r       <= 1'b0;
      l1_r        <= '0;
      o1_r        <= '0;
      l2_r        <= '0;
      o2_r        <= '0;
      mode_r      <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sec_r       <= sec_nxt;
      l1_r        <= l1_nxt;
      o1_r        <= o1_nxt;
      l2_r        <= l2_nxt;
      o2_r        <= o2_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_INPUT_MODE) begin
        mode_r <= cfg_data[0];
      end
      if (cfg_we && cfg_index == REG_BYPASS) begin
        byp_r <= cfg_data[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r          <= acc_nxt;
    tmp_r          <= tmp_nxt;
    x_r            <= x_nxt;
    e_r            <= e_nxt;
    sample_r       <= sample_nxt;
    out_filtered_r <= out_filtered_nxt;
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (st_r == ST_M0 && !sec_r))
    else $error("accepted item did not start first section");

  a_second_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_Y && sec_r) |=> (st_r == ST_G0 && !sec_r))
    else $error("second section did not hand over to gain step");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_OUT)
    else $error("result appeared outside final step");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && out_valid_r && out_stall) |=> st_r == ST_OUT)
    else $error("result overwritten while output stalled");
`endif

endmodule

FILE: src/hpf_mul.sv
// Shared multiplier: signed operand times unsigned coefficient, product registered.
module hpf_mul import hpf_pkg::*; (
  input  logic  clk,
  input  op_t   op_a,
  input  coef_t coef,
  output prod_t prod_r
);

  prod_t prod_nxt;

  assign prod_nxt = PROD_W'(op_a) * PROD_W'($signed({1'b0, coef}));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: verif/highpass_100hz_two_biquad_tb.sv
module highpass_100hz_two_biquad_tb import hpf_pkg::*;;

  // unused register indexes
  localparam logic [1:0] REG_SPARE2     = 2'd2;
  localparam logic [1:0] REG_SPARE3     = 2'd3;

  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_MARK   = 800;
  localparam int TAIL_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // filter coefficients, value * 2^24
  localparam longint POLE1_A = 31190120;
  localparam longint POLE1_B = 14509354;
  localparam longint POLE2_A = 32475909;
  localparam longint POLE2_B = 15799111;
  localparam longint OUT_GAIN = 15140229;
  localparam longint ST_HI  = (longint'(1) <<< 39) - 1;
  localparam longint ST_LO  = -(longint'(1) <<< 39);
  localparam longint OUT_HI = 8388607;
  localparam longint OUT_LO = -8388608;

  typedef logic signed [OUT_W-1:0] filt_t;
  typedef logic signed [IN_W-1:0]  smp_t;

  typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_QUIET, WAVE_EXTREME} wave_kind_t;

  typedef struct {
    bit    mode;
    bit    byp;
    smp_t  smp;
    bit    typed;
    filt_t want;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  smp_t  in_sample;
  logic  out_valid;
  logic  out_stall;
  filt_t out_filtered;
  logic  cfg_we;
  logic [1:0] cfg_index;
  logic [0:0] cfg_data;

  // shadow of the block's registers and filter state
  bit     mode_div8 = 1'b0;
  bit     bypass_on = 1'b0;
  longint last_st[2]  = '{0, 0};
  longint older_st[2] = '{0, 0};

  filt_t     filtered_q[$];
  stim_row_t dir_tab[$];
  bit        calm = 1'b0;
  int        err_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  highpass_100hz_two_biquad #(.FRACTION_BITS(16)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_filtered(out_filtered),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // round(s * c / 2^24), ties up; split keeps the partial products small
  function automatic longint coef_mul(longint s, longint c);
    longint hi_part;
    longint lo_part;
    hi_part = s >>> 24;
    lo_part = s - hi_part * (longint'(1) <<< 24);
    return hi_part * c + ((lo_part * c + (longint'(1) <<< 23)) >>> 24);
  endfunction

  // pole part, then double zero at 1, then shift the section's history
  function automatic longint run_section(int idx, longint x, longint ca, longint cb);
    longint e;
    longint y;
    e = clamp(x + coef_mul(last_st[idx], ca) - coef_mul(older_st[idx], cb), ST_LO, ST_HI);
    y = clamp(e - 2 * last_st[idx] + older_st[idx], ST_LO, ST_HI);
    older_st[idx] = last_st[idx];
    last_st[idx]  = e;
    return y;
  endfunction

  function automatic filt_t predict_filtered(smp_t smp);
    longint s;
    longint x;
    longint y;
    longint r;
    s = smp;
    x = mode_div8 ? s * 8192 : s * 65536;
    y = run_section(0, x, POLE1_A, POLE1_B);
    y = run_section(1, y, POLE2_A, POLE2_B);
    if (bypass_on) begin
      r = s * (mode_div8 ? 32 : 256);
    end else begin
      r = clamp((coef_mul(y, OUT_GAIN) + 128) >>> 8, OUT_LO, OUT_HI);
    end
    return r[OUT_W-1:0];
  endfunction

  function automatic void add_row(bit mode, bit byp, int smp, bit typed, int want);
    stim_row_t r;
    r.mode  = mode;
    r.byp   = byp;
    r.smp   = IN_W'(smp);
    r.typed = typed;
    r.want  = OUT_W'(want);
    dir_tab.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // one item; called and returns at a falling edge
  task automatic send_sample(input smp_t smp, input bit typed, input filt_t want);
    int    gap;
    filt_t pred;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    pred = predict_filtered(smp);
    filtered_q.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every expected result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input bit val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INPUT_MODE) begin
      mode_div8 = val;
    end else if (idx == REG_BYPASS) begin
      bypass_on = val;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, filtered_q.size());
    $display("highpass_100hz_two_biquad_tb: done, errors");
    $finish;
  end

  // result side: random stall before each item
  initial begin
    int k;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      k = calm ? 0 : $urandom_range(0, 8);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_filtered));
      end else begin
        if (out_filtered !== filtered_q[0]) begin
          report_mismatch($sformatf("filtered got %0d want %0d (result %0d)",
                                    out_filtered, filtered_q[0], results_checked));
        end
        void'(filtered_q.pop_front());
        results_checked++;
      end
    end
  end

  initial begin
    int         phase_len;
    int         k;
    int         p;
    int         amp;
    int         phases;
    int         random_sent;
    bit         drained_midway;
    wave_kind_t wave;
    smp_t       smp;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    phases = 0;
    random_sent = 0;
    drained_midway = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero from reset, extremes in both modes, bypass values
    add_row(0, 0, 0, 1, 0);
    add_row(0, 0, 32767, 0, 0);
    add_row(0, 0, -32768, 0, 0);
    add_row(0, 0, 32767, 0, 0);
    add_row(0, 0, -32768, 0, 0);
    add_row(0, 0, 1, 0, 0);
    add_row(0, 0, -1, 0, 0);
    add_row(0, 0, 0, 0, 0);
    add_row(1, 0, 32767, 0, 0);
    add_row(1, 0, -32768, 0, 0);
    add_row(1, 0, 8, 0, 0);
    add_row(1, 0, -8, 0, 0);
    add_row(1, 0, -1, 0, 0);
    add_row(0, 1, 32767, 1, 8388352);
    add_row(0, 1, -32768, 1, -8388608);
    add_row(0, 1, 1, 1, 256);
    add_row(1, 1, 32767, 1, 1048544);
    add_row(1, 1, -32768, 1, -1048576);
    add_row(1, 1, -1, 1, -32);
    add_row(0, 0, 16384, 0, 0);
    add_row(0, 0, -16385, 0, 0);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != mode_div8 || dir_tab[i].byp != bypass_on) begin
        wait_idle();
        write_reg(REG_INPUT_MODE, dir_tab[i].mode);
        write_reg(REG_BYPASS, dir_tab[i].byp);
      end
      send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
    end

    // unused indexes must leave the registers alone
    wait_idle();
    write_reg(REG_SPARE2, 1'b1);
    write_reg(REG_SPARE3, 1'b1);
    send_sample(16'sd32767, 1'b0, '0);

    // random phases: one setting and one waveform per phase
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      write_reg(REG_INPUT_MODE, 1'($urandom_range(0, 1)));
      write_reg(REG_BYPASS, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
                  1'($urandom_range(0, 1)));
      end
      calm      = ($urandom_range(0, 4) == 0);
      wave      = wave_kind_t'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 120);
      p         = $urandom_range(4, 100);
      amp       = $urandom_range(8192, 32767);
      for (k = 0; k < phase_len; k++) begin
        case (wave)
          WAVE_NOISE: begin
            smp = IN_W'($urandom);
          end
          WAVE_SQUARE: begin
            // square of amplitude 8192 to 32767, period 4 to 100 samples, drives the state hard
            smp = IN_W'(((k % p) < (p / 2)) ? amp : -amp - 1);
          end
          WAVE_QUIET: begin
            smp = IN_W'($urandom_range(0, 511) - 256);
          end
          default: begin
            case ($urandom_range(0, 4))
              0: smp = 16'sd32767;
              1: smp = -16'sd32768;
              2: smp = 16'sd0;
              3: smp = 16'sd1;
              default: smp = -16'sd1;
            endcase
          end
        endcase
        // hold the sender once mid-phase until the block is empty
        if (!drained_midway && random_sent == DRAIN_MARK) begin
          wait_idle();
          drained_midway = 1'b1;
        end
        send_sample(smp, 1'b0, '0);
        random_sent++;
      end
      phases++;
    end

    calm = 1'b0;
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (filtered_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never came", filtered_q.size()));
    end

    $display("sent %0d samples (%0d directed, %0d random in %0d phases), checked %0d results",
             items_sent, dir_tab.size() + 1, random_sent, phases, results_checked);
    $display("both input scalings, filter and bypass, noise, square, quiet and extreme inputs");
    if (err_count == 0) begin
      $display("highpass_100hz_two_biquad_tb: done, clean");
    end else begin
      $display("highpass_100hz_two_biquad_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
src/hpf_pkg.sv
src/hpf_mul.sv
src/highpass_100hz_two_biquad.sv
verif/highpass_100hz_two_biquad_tb.sv
